// ----- hw/rtl/sfe_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sensor filter package
// Shared constants, configuration codes and the low-pass tap table.
// ----------------------------------------------------------------------------
package sfe_pkg;

  localparam int unsigned OUT_BITS       = 16;
  localparam int unsigned OUT_MAX        = 65535;
  localparam int unsigned FRAC_BITS      = 16;
  localparam int unsigned ROUND_SHIFT    = 12;
  localparam int unsigned ROUND_HALF     = 2048;
  localparam int unsigned TAP_BITS       = 16;
  localparam int unsigned TAP_IDX_BITS   = 5;
  localparam int unsigned KNOWN_TAPS     = 11;
  localparam int unsigned WEIGHT_BITS    = 16;
  localparam int unsigned CFG_INDEX_BITS = 1;
  localparam int unsigned CFG_DATA_BITS  = 16;

  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

  localparam cfg_index_t CFG_FILTER_MODE    = cfg_index_t'(0);
  localparam cfg_index_t CFG_AVERAGE_WEIGHT = cfg_index_t'(1);

  typedef enum logic {
    MODE_FIR     = 1'b0,
    MODE_AVERAGE = 1'b1
  } filter_mode_e;

  localparam logic [WEIGHT_BITS-1:0] WEIGHT_RESET = 16'd4588;

  localparam logic [TAP_BITS-1:0] TAP_TABLE [KNOWN_TAPS] = '{
    16'd1401, 16'd2887, 16'd4969, 16'd7070, 16'd8638, 16'd9220,
    16'd8638, 16'd7070, 16'd4969, 16'd2887, 16'd1401
  };

  // Taps past the designed set are zero.
  function automatic logic [TAP_BITS-1:0] tap_coeff(input logic [TAP_IDX_BITS-1:0] k);
    logic [TAP_BITS-1:0] c;
    c = '0;
    if (k < TAP_IDX_BITS'(KNOWN_TAPS)) begin
      c = TAP_TABLE[k[3:0]];
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/sfe_round.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Round and saturate
// Converts a Q.16 value to unsigned 12.4, rounded half up, clamped to 16 bits.
// ----------------------------------------------------------------------------
module sfe_round import sfe_pkg::*; #(
  parameter int unsigned IN_BITS = 28
) (
  input  wire logic [IN_BITS-1:0]  value_i,
  output logic      [OUT_BITS-1:0] value_o
);

  localparam int unsigned RND_BITS = IN_BITS + 1 - ROUND_SHIFT;
  localparam int unsigned CMP_BITS = (RND_BITS > OUT_BITS) ? RND_BITS : OUT_BITS;

  logic [IN_BITS:0]    biased;
  logic [RND_BITS-1:0] rnd;

  always_comb begin
    biased  = {1'b0, value_i} + (IN_BITS + 1)'(ROUND_HALF);
    rnd     = RND_BITS'(biased >> ROUND_SHIFT);
    value_o = OUT_BITS'(rnd);
    if (CMP_BITS'(rnd) > CMP_BITS'(OUT_MAX)) begin
      value_o = '1;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/sfe_fir.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Symmetric low-pass FIR
// Delay line of past samples and the constant-tap sum of products.
// ----------------------------------------------------------------------------
module sfe_fir import sfe_pkg::*; #(
  parameter int unsigned TAP_COUNT   = 11,
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   advance_i,
  input  wire logic [SAMPLE_BITS-1:0] sample_i,
  output logic      [OUT_BITS-1:0]    fir_o
);

  localparam int unsigned DEPTH    = TAP_COUNT - 1;
  // Tap set sums below 2^16, so the sum fits in sample plus tap width.
  localparam int unsigned ACC_BITS = SAMPLE_BITS + TAP_BITS;

  logic [SAMPLE_BITS-1:0] delay_q [DEPTH];
  logic [ACC_BITS-1:0]    acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) begin
        delay_q[i] <= '0;
      end
    end else if (advance_i) begin
      delay_q[0] <= sample_i;
      for (int i = 1; i < DEPTH; i++) begin
        delay_q[i] <= delay_q[i-1];
      end
    end
  end

  always_comb begin
    acc = ACC_BITS'(sample_i) * ACC_BITS'(tap_coeff(TAP_IDX_BITS'(0)));
    for (int i = 0; i < DEPTH; i++) begin
      acc = acc + ACC_BITS'(delay_q[i]) * ACC_BITS'(tap_coeff(TAP_IDX_BITS'(i + 1)));
    end
  end

  sfe_round #(
    .IN_BITS (ACC_BITS)
  ) u_round (
    .value_i (acc),
    .value_o (fir_o)
  );

endmodule
`default_nettype wire

// ----- hw/rtl/sfe_ema.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Exponential moving average
// Q.16 average register updated as y + w*(x - y), rounded half up.
// ----------------------------------------------------------------------------
module sfe_ema import sfe_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   advance_i,
  input  wire logic [SAMPLE_BITS-1:0] sample_i,
  input  wire logic [WEIGHT_BITS-1:0] weight_i,
  output logic      [OUT_BITS-1:0]    avg_o
);

  localparam int unsigned AVG_BITS  = SAMPLE_BITS + FRAC_BITS;
  localparam int unsigned INV_BITS  = WEIGHT_BITS + 1;
  localparam int unsigned PY_BITS   = AVG_BITS + INV_BITS;
  localparam int unsigned PX_BITS   = SAMPLE_BITS + WEIGHT_BITS;
  localparam int unsigned SUM_BITS  = SAMPLE_BITS + FRAC_BITS + INV_BITS + 1;

  logic [AVG_BITS-1:0] avg_q, avg_d;
  logic [INV_BITS-1:0] inv_w;
  logic [PY_BITS-1:0]  prod_y;
  logic [PX_BITS-1:0]  prod_x;
  logic [SUM_BITS-1:0] sum;

  always_comb begin
    inv_w  = (INV_BITS'(1) << FRAC_BITS) - INV_BITS'(weight_i);
    prod_y = PY_BITS'(avg_q) * PY_BITS'(inv_w);
    prod_x = PX_BITS'(sample_i) * PX_BITS'(weight_i);
    sum    = SUM_BITS'(prod_y) + (SUM_BITS'(prod_x) << FRAC_BITS)
           + (SUM_BITS'(1) << (FRAC_BITS - 1));
    avg_d  = AVG_BITS'(sum >> FRAC_BITS);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_q <= '0;
    end else if (advance_i) begin
      avg_q <= avg_d;
    end
  end

  // Output reflects the updated average.
  sfe_round #(
    .IN_BITS (AVG_BITS)
  ) u_round (
    .value_i (avg_d),
    .value_o (avg_o)
  );

endmodule
`default_nettype wire

// ----- hw/rtl/sensor_fir_or_ema_filter.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Path: input register, then result register, which drives filtered_o.
// Throughput: one sample per cycle; the input register and the result
// register each transfer every cycle when the output side does not stall.
// Reset: delay line, average and valid flags clear; mode resets to average,
// weight resets to 4588 (0.07 in Q0.16).
// ----------------------------------------------------------------------------
// Sensor FIR / moving-average filter
// Input register, FIR and average datapaths, mode select, result register.
// ----------------------------------------------------------------------------
module sensor_fir_or_ema_filter import sfe_pkg::*; #(
  parameter int unsigned TAP_COUNT   = 11,
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     sample_valid_i,
  output logic                          sample_stall_o,
  input  wire logic [SAMPLE_BITS-1:0]   sample_i,
  output logic                          filtered_valid_o,
  input  wire logic                     filtered_stall_i,
  output logic      [OUT_BITS-1:0]      filtered_o,
  input  wire logic                     cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index_i,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data_i
);

  filter_mode_e           mode_q;
  logic [WEIGHT_BITS-1:0] weight_q;

  logic                   s1_valid_q;
  logic [SAMPLE_BITS-1:0] sample_q;
  logic                   out_valid_q;
  logic [OUT_BITS-1:0]    filtered_q;

  logic                   out_free;
  logic                   s1_adv;
  logic [OUT_BITS-1:0]    fir_out;
  logic [OUT_BITS-1:0]    avg_out;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_AVERAGE;
      weight_q <= WEIGHT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_FILTER_MODE:    mode_q   <= filter_mode_e'(cfg_data_i[0]);
        CFG_AVERAGE_WEIGHT: weight_q <= WEIGHT_BITS'(cfg_data_i);
        default:            ;
      endcase
    end
  end

  assign out_free       = !out_valid_q || !filtered_stall_i;
  assign s1_adv         = s1_valid_q && out_free;
  assign sample_stall_o = s1_valid_q && !out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!sample_stall_o) begin
        s1_valid_q <= sample_valid_i;
      end
      if (out_free) begin
        out_valid_q <= s1_adv;
      end
    end
  end

  // Payload registers load on transfer only.
  always_ff @(posedge clk_i) begin
    if (sample_valid_i && !sample_stall_o) begin
      sample_q <= sample_i;
    end
    if (s1_adv) begin
      filtered_q <= (mode_q == MODE_AVERAGE) ? avg_out : fir_out;
    end
  end

  // Both filters advance on every sample; mode only picks the result.
  sfe_fir #(
    .TAP_COUNT   (TAP_COUNT),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_fir (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (s1_adv),
    .sample_i  (sample_q),
    .fir_o     (fir_out)
  );

  sfe_ema #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_ema (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (s1_adv),
    .sample_i  (sample_q),
    .weight_i  (weight_q),
    .avg_o     (avg_out)
  );

  assign filtered_valid_o = out_valid_q;
  assign filtered_o       = filtered_q;

  a_no_adv_when_blocked: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && filtered_stall_i) |-> !s1_adv
  ) else $error("input stage advanced into a stalled result register");

  a_stall_needs_item: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    sample_stall_o |-> s1_valid_q
  ) else $error("input stalled with an empty input register");

  a_adv_fills_result: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_q
  ) else $error("advanced item did not reach the result register");

  a_result_drains: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !filtered_stall_i && !s1_valid_q) |=> !out_valid_q
  ) else $error("result repeated after transfer");

endmodule
`default_nettype wire
